// ===== rtl/disparity_to_point_reprojection_top_assert.svh =====
// ----------------------------------------------------------------------------
// Disparity to point reprojection assertion macros
// Shared concurrent assertion forms used by the block's modules.
// ----------------------------------------------------------------------------
`ifndef DISPARITY_TO_POINT_REPROJECTION_TOP_ASSERT_SVH
`define DISPARITY_TO_POINT_REPROJECTION_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define DTP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while in reset.
`define DTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/dtp_pkg.sv =====
// ----------------------------------------------------------------------------
// Disparity to point reprojection package
// Widths, register codes, shared types and arithmetic helpers.
// ----------------------------------------------------------------------------
package dtp_pkg;

    localparam int COORD_BITS     = 12;
    localparam int DISPARITY_BITS = 16;
    localparam int OUT_W          = 26;
    localparam int FOCAL_W        = 20;
    localparam int CENTER_W       = 16;
    localparam int BASE_W         = 16;
    localparam int LIMIT_W        = 26;
    localparam int CFG_DATA_W     = 26;
    localparam int CFG_IDX_W      = 3;
    localparam int NUM_W          = FOCAL_W + BASE_W;
    localparam int Q_W            = OUT_W;
    localparam int NUM_HI_W       = NUM_W - Q_W;
    localparam int DZ_W           = DISPARITY_BITS + 6;
    localparam int POS_W          = COORD_BITS + 4;
    localparam int MAG_W          = (POS_W > CENTER_W) ? POS_W : CENTER_W;
    localparam int PROD_W         = MAG_W + Q_W;
    localparam int DIV_W          = (DZ_W > FOCAL_W) ? DZ_W : FOCAL_W;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_W     = 2;
    localparam int FIFO_CNT_W     = 3;

    localparam logic [FOCAL_W-1:0]  RST_FOCAL_X  = FOCAL_W'(8000);
    localparam logic [FOCAL_W-1:0]  RST_FOCAL_Y  = FOCAL_W'(8000);
    localparam logic [CENTER_W-1:0] RST_CENTER_X = CENTER_W'(5120);
    localparam logic [CENTER_W-1:0] RST_CENTER_Y = CENTER_W'(3840);
    localparam logic [BASE_W-1:0]   RST_BASELINE = BASE_W'(7864);
    localparam logic [LIMIT_W-1:0]  RST_NEAR     = LIMIT_W'(205);
    localparam logic [LIMIT_W-1:0]  RST_FAR      = LIMIT_W'(10240);

    localparam logic [OUT_W-1:0] POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] NEG_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCAL_X  = 3'd0,
        CFG_FOCAL_Y  = 3'd1,
        CFG_CENTER_X = 3'd2,
        CFG_CENTER_Y = 3'd3,
        CFG_BASELINE = 3'd4,
        CFG_NEAR     = 3'd5,
        CFG_FAR      = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [FOCAL_W-1:0]  focal_x;
        logic [FOCAL_W-1:0]  focal_y;
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [BASE_W-1:0]   stereo_baseline;
        logic [LIMIT_W-1:0]  near_limit;
        logic [LIMIT_W-1:0]  far_limit;
    } cfg_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DZ_W-1:0]  dz;
        logic [MAG_W-1:0] magx;
        logic             negx;
        logic [MAG_W-1:0] magy;
        logic             negy;
    } item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

    // One restoring division step: returns {quotient bit, new remainder}.
    function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] rem,
                                                input logic             bin,
                                                input logic [DIV_W-1:0] d);
        logic [DIV_W:0] t;
        logic [DIV_W:0] diff;
        t    = {rem, bin};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d})
            return {1'b1, diff[DIV_W-1:0]};
        else
            return {1'b0, t[DIV_W-1:0]};
    endfunction

    // Applies the sign to a quotient magnitude and saturates to the output range.
    function automatic logic [OUT_W-1:0] lateral_sat(input logic [Q_W-1:0] q,
                                                     input logic           neg,
                                                     input logic           ovf);
        logic [OUT_W-1:0] r;
        if (neg) begin
            if (ovf || (q > NEG_MIN))
                r = NEG_MIN;
            else
                r = OUT_W'(-q);
        end
        else begin
            if (ovf || q[Q_W-1])
                r = POS_MAX;
            else
                r = q;
        end
        return r;
    endfunction

endpackage

// ===== rtl/disparity_to_point_reprojection_top.sv =====
// ----------------------------------------------------------------------------
// Disparity to point reprojection top level
// Turns disparity map pixels into camera-frame points in 1/1024 m units.
// ----------------------------------------------------------------------------
//
//  Channel   | Ports                                             | Transfer when
//  ----------+---------------------------------------------------+----------------------
//  pixel in  | pixel_column, pixel_row, disparity,               | start && !busy
//            | disparity_valid                                   |
//  point out | point_x, point_y, point_z                         | result_valid (1 cycle)
//  config    | cfg_index, cfg_wdata                              | cfg_we
//
// One pixel can be transferred in every clock cycle while busy is low. Each
// pixel that gives a point passes the front end register, the queue, the
// depth divider entry register, 26 one-bit depth division steps, the window
// check and products register, the lateral divider entry register, 26
// lateral division steps and the output register; the dividers work one
// quotient bit per stage. Reset clears all valid flags and loads the
// register defaults; the point receiver cannot stall, so busy stays low in
// normal operation.
//
module disparity_to_point_reprojection_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [dtp_pkg::COORD_BITS-1:0]       pixel_column,
    input  logic [dtp_pkg::COORD_BITS-1:0]       pixel_row,
    input  logic [dtp_pkg::DISPARITY_BITS-1:0]   disparity,
    input  logic                                 disparity_valid,
    input  logic                                 cfg_we,
    input  logic [dtp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dtp_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    output logic                                 result_valid,
    output logic signed [dtp_pkg::OUT_W-1:0]     point_x,
    output logic signed [dtp_pkg::OUT_W-1:0]     point_y,
    output logic [dtp_pkg::OUT_W-1:0]            point_z
);

    dtp_pkg::cfg_t        cfg_reg;
    dtp_pkg::cfg_t        cfg_next;
    dtp_pkg::fifo_stat_t  fifo_stat;
    dtp_pkg::item_t       front_item;
    dtp_pkg::item_t       head_item;
    logic                 front_valid;
    logic                 accept;
    logic                 pop;

    // The pixel transfer happens when start is seen while the queue has room.
    assign busy   = fifo_stat.full;
    assign accept = start && !busy;

    // Configuration writes land directly; indexes past the register list are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (dtp_pkg::cfg_idx_t'(cfg_index))
                dtp_pkg::CFG_FOCAL_X:  cfg_next.focal_x = cfg_wdata[dtp_pkg::FOCAL_W-1:0];
                dtp_pkg::CFG_FOCAL_Y:  cfg_next.focal_y = cfg_wdata[dtp_pkg::FOCAL_W-1:0];
                dtp_pkg::CFG_CENTER_X: cfg_next.center_x = cfg_wdata[dtp_pkg::CENTER_W-1:0];
                dtp_pkg::CFG_CENTER_Y: cfg_next.center_y = cfg_wdata[dtp_pkg::CENTER_W-1:0];
                dtp_pkg::CFG_BASELINE:
                    cfg_next.stereo_baseline = cfg_wdata[dtp_pkg::BASE_W-1:0];
                dtp_pkg::CFG_NEAR:     cfg_next.near_limit = cfg_wdata[dtp_pkg::LIMIT_W-1:0];
                dtp_pkg::CFG_FAR:      cfg_next.far_limit = cfg_wdata[dtp_pkg::LIMIT_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focal_x         <= dtp_pkg::RST_FOCAL_X;
            cfg_reg.focal_y         <= dtp_pkg::RST_FOCAL_Y;
            cfg_reg.center_x        <= dtp_pkg::RST_CENTER_X;
            cfg_reg.center_y        <= dtp_pkg::RST_CENTER_Y;
            cfg_reg.stereo_baseline <= dtp_pkg::RST_BASELINE;
            cfg_reg.near_limit      <= dtp_pkg::RST_NEAR;
            cfg_reg.far_limit       <= dtp_pkg::RST_FAR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: drops pixels without a usable disparity and forms the operands.
    dtp_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .pixel_column    (pixel_column),
        .pixel_row       (pixel_row),
        .disparity       (disparity),
        .disparity_valid (disparity_valid),
        .cfg             (cfg_reg),
        .item_valid      (front_valid),
        .item            (front_item)
    );

    // Queue between the two halves.
    dtp_fifo u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (front_valid),
        .wr_data (front_item),
        .pop     (pop),
        .rd_data (head_item),
        .stat    (fifo_stat)
    );

    // Back end: depth, window check and lateral coordinates.
    dtp_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .stat         (fifo_stat),
        .item         (head_item),
        .cfg          (cfg_reg),
        .pop          (pop),
        .result_valid (result_valid),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z)
    );

endmodule

// ===== rtl/dtp_front.sv =====
// ----------------------------------------------------------------------------
// Disparity to point reprojection front end
// Accepts pixels, drops invalid ones, forms the depth operands and offsets.
// ----------------------------------------------------------------------------
module dtp_front
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic [dtp_pkg::COORD_BITS-1:0]       pixel_column,
    input  logic [dtp_pkg::COORD_BITS-1:0]       pixel_row,
    input  logic [dtp_pkg::DISPARITY_BITS-1:0]   disparity,
    input  logic                                 disparity_valid,
    input  dtp_pkg::cfg_t                        cfg,
    output logic                                 item_valid,
    output dtp_pkg::item_t                       item
);

    logic                       item_valid_reg;
    logic                       item_valid_next;
    dtp_pkg::item_t             item_reg;
    dtp_pkg::item_t             item_next;
    logic [dtp_pkg::MAG_W-1:0]  posx;
    logic [dtp_pkg::MAG_W-1:0]  posy;
    logic [dtp_pkg::MAG_W-1:0]  cx;
    logic [dtp_pkg::MAG_W-1:0]  cy;

    always_comb
    begin
        posx = dtp_pkg::MAG_W'({pixel_column, 4'b0000});
        posy = dtp_pkg::MAG_W'({pixel_row, 4'b0000});
        cx   = dtp_pkg::MAG_W'(cfg.center_x);
        cy   = dtp_pkg::MAG_W'(cfg.center_y);

        item_valid_next = accept && disparity_valid && (disparity != '0);

        item_next.num  = dtp_pkg::NUM_W'(cfg.focal_x) * dtp_pkg::NUM_W'(cfg.stereo_baseline);
        item_next.dz   = {disparity, 6'b000000};
        item_next.negx = posx < cx;
        item_next.magx = item_next.negx ? (cx - posx) : (posx - cx);
        item_next.negy = posy < cy;
        item_next.magy = item_next.negy ? (cy - posy) : (posy - cy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= item_valid_next;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/dtp_fifo.sv =====
// ----------------------------------------------------------------------------
// Disparity to point reprojection item queue
// Short queue that decouples the front end from the arithmetic back end.
// ----------------------------------------------------------------------------
`include "disparity_to_point_reprojection_top_assert.svh"

module dtp_fifo
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  dtp_pkg::item_t        wr_data,
    input  logic                  pop,
    output dtp_pkg::item_t        rd_data,
    output dtp_pkg::fifo_stat_t   stat
);

    dtp_pkg::item_t                    mem [0:dtp_pkg::FIFO_DEPTH-1];
    logic [dtp_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg;
    logic [dtp_pkg::FIFO_PTR_W-1:0]    wr_ptr_next;
    logic [dtp_pkg::FIFO_PTR_W-1:0]    rd_ptr_reg;
    logic [dtp_pkg::FIFO_PTR_W-1:0]    rd_ptr_next;
    logic [dtp_pkg::FIFO_CNT_W-1:0]    count_reg;
    logic [dtp_pkg::FIFO_CNT_W-1:0]    count_next;
    logic                              do_push;
    logic                              do_pop;

    always_comb
    begin
        stat.empty  = (count_reg == '0);
        stat.full   = (count_reg == dtp_pkg::FIFO_CNT_W'(dtp_pkg::FIFO_DEPTH));
        do_pop      = pop && !stat.empty;
        do_push     = push && (!stat.full || do_pop);
        wr_ptr_next = do_push ? (wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_data;
    end

    assign rd_data = mem[rd_ptr_reg];

    // A push into a full queue is only safe when the head leaves in the same cycle.
    `DTP_ASSERT_IMPLY(a_no_overflow, clk, rst_n, push && stat.full, pop)
    `DTP_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= dtp_pkg::FIFO_DEPTH)
    `DTP_ASSERT_NEXT(a_pop_drains, clk, rst_n, do_pop && !do_push, count_reg == $past(count_reg) - 1'b1)

endmodule

// ===== rtl/dtp_back.sv =====
// ----------------------------------------------------------------------------
// Disparity to point reprojection back end
// Pipelined depth division, window check, products and lateral divisions.
// ----------------------------------------------------------------------------
`include "disparity_to_point_reprojection_top_assert.svh"

module dtp_back
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  dtp_pkg::fifo_stat_t                stat,
    input  dtp_pkg::item_t                     item,
    input  dtp_pkg::cfg_t                      cfg,
    output logic                               pop,
    output logic                               result_valid,
    output logic signed [dtp_pkg::OUT_W-1:0]   point_x,
    output logic signed [dtp_pkg::OUT_W-1:0]   point_y,
    output logic [dtp_pkg::OUT_W-1:0]          point_z
);

    localparam int QW = dtp_pkg::Q_W;

    typedef struct packed {
        logic [dtp_pkg::DIV_W-1:0] rem;
        logic [QW-1:0]             low;
        logic [dtp_pkg::DZ_W-1:0]  d;
        logic [dtp_pkg::MAG_W-1:0] magx;
        logic                      negx;
        logic [dtp_pkg::MAG_W-1:0] magy;
        logic                      negy;
    } zst_t;

    typedef struct packed {
        logic [dtp_pkg::PROD_W-1:0] px;
        logic [dtp_pkg::PROD_W-1:0] py;
        logic [QW-1:0]              z;
        logic                       negx;
        logic                       negy;
    } mst_t;

    typedef struct packed {
        logic [dtp_pkg::DIV_W-1:0] remx;
        logic [QW-1:0]             lowx;
        logic                      ovfx;
        logic                      negx;
        logic [dtp_pkg::DIV_W-1:0] remy;
        logic [QW-1:0]             lowy;
        logic                      ovfy;
        logic                      negy;
        logic [QW-1:0]             z;
    } lst_t;

    logic [QW:0]                  zv_reg;
    logic [QW:0]                  zv_next;
    zst_t                         zs_reg  [0:QW];
    zst_t                         zs_next [0:QW];
    logic [dtp_pkg::DIV_W:0]      zstep   [1:QW];
    logic                         mv_reg;
    logic                         mv_next;
    mst_t                         ms_reg;
    mst_t                         ms_next;
    logic [QW:0]                  lv_reg;
    logic [QW:0]                  lv_next;
    lst_t                         ls_reg  [0:QW];
    lst_t                         ls_next [0:QW];
    logic [dtp_pkg::DIV_W:0]      xstep   [1:QW];
    logic [dtp_pkg::DIV_W:0]      ystep   [1:QW];
    logic [dtp_pkg::FOCAL_W-1:0]  fx;
    logic [dtp_pkg::FOCAL_W-1:0]  fy;
    logic [QW-1:0]                zq;
    logic                         result_valid_reg;
    logic                         result_valid_next;
    logic [dtp_pkg::OUT_W-1:0]    px_reg;
    logic [dtp_pkg::OUT_W-1:0]    px_next;
    logic [dtp_pkg::OUT_W-1:0]    py_reg;
    logic [dtp_pkg::OUT_W-1:0]    py_next;
    logic [dtp_pkg::OUT_W-1:0]    pz_reg;
    logic [dtp_pkg::OUT_W-1:0]    pz_next;

    assign pop = !stat.empty;

    always_comb
    begin
        // A zero focal length divides as if it were one.
        fx = (cfg.focal_x == '0) ? dtp_pkg::FOCAL_W'(1) : cfg.focal_x;
        fy = (cfg.focal_y == '0) ? dtp_pkg::FOCAL_W'(1) : cfg.focal_y;

        // Depth division entry: a quotient of 2^26 or more lies beyond any far limit.
        zv_next[0]      = pop && (dtp_pkg::DIV_W'(item.num[dtp_pkg::NUM_W-1:QW])
                                  < dtp_pkg::DIV_W'(item.dz));
        zs_next[0].rem  = dtp_pkg::DIV_W'(item.num[dtp_pkg::NUM_W-1:QW]);
        zs_next[0].low  = item.num[QW-1:0];
        zs_next[0].d    = item.dz;
        zs_next[0].magx = item.magx;
        zs_next[0].negx = item.negx;
        zs_next[0].magy = item.magy;
        zs_next[0].negy = item.negy;

        for (int k = 1; k <= QW; k++)
        begin
            zstep[k] = dtp_pkg::div_step(zs_reg[k-1].rem, zs_reg[k-1].low[QW-1],
                                         dtp_pkg::DIV_W'(zs_reg[k-1].d));
            zs_next[k]     = zs_reg[k-1];
            zs_next[k].rem = zstep[k][dtp_pkg::DIV_W-1:0];
            zs_next[k].low = {zs_reg[k-1].low[QW-2:0], zstep[k][dtp_pkg::DIV_W]};
            zv_next[k]     = zv_reg[k-1];
        end

        zq           = zs_reg[QW].low;
        mv_next      = zv_reg[QW] && (zq >= cfg.near_limit) && (zq <= cfg.far_limit);
        ms_next.px   = dtp_pkg::PROD_W'(zs_reg[QW].magx) * dtp_pkg::PROD_W'(zq);
        ms_next.py   = dtp_pkg::PROD_W'(zs_reg[QW].magy) * dtp_pkg::PROD_W'(zq);
        ms_next.z    = zq;
        ms_next.negx = zs_reg[QW].negx;
        ms_next.negy = zs_reg[QW].negy;

        lv_next[0]      = mv_reg;
        ls_next[0].ovfx = dtp_pkg::DIV_W'(ms_reg.px[dtp_pkg::PROD_W-1:QW])
                          >= dtp_pkg::DIV_W'(fx);
        ls_next[0].ovfy = dtp_pkg::DIV_W'(ms_reg.py[dtp_pkg::PROD_W-1:QW])
                          >= dtp_pkg::DIV_W'(fy);
        ls_next[0].remx = ls_next[0].ovfx ? '0
                          : dtp_pkg::DIV_W'(ms_reg.px[dtp_pkg::PROD_W-1:QW]);
        ls_next[0].remy = ls_next[0].ovfy ? '0
                          : dtp_pkg::DIV_W'(ms_reg.py[dtp_pkg::PROD_W-1:QW]);
        ls_next[0].lowx = ms_reg.px[QW-1:0];
        ls_next[0].lowy = ms_reg.py[QW-1:0];
        ls_next[0].negx = ms_reg.negx;
        ls_next[0].negy = ms_reg.negy;
        ls_next[0].z    = ms_reg.z;

        for (int k = 1; k <= QW; k++)
        begin
            xstep[k] = dtp_pkg::div_step(ls_reg[k-1].remx, ls_reg[k-1].lowx[QW-1],
                                         dtp_pkg::DIV_W'(fx));
            ystep[k] = dtp_pkg::div_step(ls_reg[k-1].remy, ls_reg[k-1].lowy[QW-1],
                                         dtp_pkg::DIV_W'(fy));
            ls_next[k]      = ls_reg[k-1];
            ls_next[k].remx = xstep[k][dtp_pkg::DIV_W-1:0];
            ls_next[k].lowx = {ls_reg[k-1].lowx[QW-2:0], xstep[k][dtp_pkg::DIV_W]};
            ls_next[k].remy = ystep[k][dtp_pkg::DIV_W-1:0];
            ls_next[k].lowy = {ls_reg[k-1].lowy[QW-2:0], ystep[k][dtp_pkg::DIV_W]};
            lv_next[k]      = lv_reg[k-1];
        end

        result_valid_next = lv_reg[QW];
        px_next = dtp_pkg::lateral_sat(ls_reg[QW].lowx, ls_reg[QW].negx, ls_reg[QW].ovfx);
        py_next = dtp_pkg::lateral_sat(ls_reg[QW].lowy, ls_reg[QW].negy, ls_reg[QW].ovfy);
        pz_next = ls_reg[QW].z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zv_reg           <= '0;
            mv_reg           <= 1'b0;
            lv_reg           <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            zv_reg           <= zv_next;
            mv_reg           <= mv_next;
            lv_reg           <= lv_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= QW; k++)
        begin
            zs_reg[k] <= zs_next[k];
            ls_reg[k] <= ls_next[k];
        end
        ms_reg <= ms_next;
        px_reg <= px_next;
        py_reg <= py_next;
        pz_reg <= pz_next;
    end

    assign result_valid = result_valid_reg;
    assign point_x      = px_reg;
    assign point_y      = py_reg;
    assign point_z      = pz_reg;

    // Depth is in the window while the user keeps configuration steady; unenforced.
    `DTP_ASSERT_IMPLY(a_z_in_window, clk, rst_n, result_valid_reg, (pz_reg >= cfg.near_limit) && (pz_reg <= cfg.far_limit))
    `DTP_ASSERT_NEXT(a_window_needs_depth, clk, rst_n, !zv_reg[QW], !mv_reg)
    `DTP_ASSERT_NEXT(a_result_needs_lateral, clk, rst_n, !lv_reg[QW], !result_valid_reg)

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Disparity to point reprojection testbench
// Drives disparity pixels in bursts, predicts each point the block should
// emit and compares every emitted point field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct packed {
        logic [dtp_pkg::OUT_W-1:0] x;
        logic [dtp_pkg::OUT_W-1:0] y;
        logic [dtp_pkg::OUT_W-1:0] z;
    } point_t;

    // One row of the directed table. When typed is set, the point (or its
    // absence, has_point low) is written in by hand instead of predicted.
    typedef struct {
        logic [dtp_pkg::COORD_BITS-1:0]     col;
        logic [dtp_pkg::COORD_BITS-1:0]     row;
        logic [dtp_pkg::DISPARITY_BITS-1:0] disp;
        logic                               valid;
        bit                                 typed;
        bit                                 has_point;
        point_t                             pt;
    } pixel_row_t;

    localparam int DRAIN_CYCLES = 70;

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    logic [dtp_pkg::COORD_BITS-1:0]     pixel_column;
    logic [dtp_pkg::COORD_BITS-1:0]     pixel_row;
    logic [dtp_pkg::DISPARITY_BITS-1:0] disparity;
    logic                               disparity_valid;
    logic                               cfg_we;
    logic [dtp_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [dtp_pkg::CFG_DATA_W-1:0]     cfg_wdata;
    logic                               result_valid;
    logic signed [dtp_pkg::OUT_W-1:0]   point_x;
    logic signed [dtp_pkg::OUT_W-1:0]   point_y;
    logic [dtp_pkg::OUT_W-1:0]          point_z;

    // Shadow copy of the camera registers, kept in step with every write.
    logic [dtp_pkg::FOCAL_W-1:0]  cam_fx;
    logic [dtp_pkg::FOCAL_W-1:0]  cam_fy;
    logic [dtp_pkg::CENTER_W-1:0] cam_cx;
    logic [dtp_pkg::CENTER_W-1:0] cam_cy;
    logic [dtp_pkg::BASE_W-1:0]   cam_base;
    logic [dtp_pkg::LIMIT_W-1:0]  cam_near;
    logic [dtp_pkg::LIMIT_W-1:0]  cam_far;

    point_t pending_points[$];
    int     error_count;
    int     burst_left;

    disparity_to_point_reprojection_top dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .pixel_column    (pixel_column),
        .pixel_row       (pixel_row),
        .disparity       (disparity),
        .disparity_valid (disparity_valid),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .result_valid    (result_valid),
        .point_x         (point_x),
        .point_y         (point_y),
        .point_z         (point_z)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Lateral offset times depth over focal length, truncated toward zero and
    // saturated to the signed output range. A zero focal length divides as 1.
    function automatic logic [dtp_pkg::OUT_W-1:0] lateral_coord(
        input longint unsigned pix,
        input longint unsigned center,
        input longint unsigned depth,
        input longint unsigned focal);
        longint unsigned pos;
        longint unsigned mag;
        longint unsigned q;
        bit              neg;
        pos = pix * 16;
        neg = pos < center;
        mag = neg ? (center - pos) : (pos - center);
        q   = (mag * depth) / ((focal == 0) ? 1 : focal);
        if (neg)
            return (q > 64'd33554432) ? dtp_pkg::NEG_MIN : dtp_pkg::OUT_W'(-q);
        else
            return (q > 64'd33554431) ? dtp_pkg::POS_MAX : dtp_pkg::OUT_W'(q);
    endfunction

    // Works out the point for one pixel under the current register shadow.
    // Returns 0 where the pixel gives no point.
    function automatic bit predict_point(input logic [dtp_pkg::COORD_BITS-1:0]     col,
                                         input logic [dtp_pkg::COORD_BITS-1:0]     row,
                                         input logic [dtp_pkg::DISPARITY_BITS-1:0] disp,
                                         input logic                               valid,
                                         output point_t                            pt);
        longint unsigned depth;
        pt = '0;
        if (!valid || disp == 0)
            return 0;
        depth = (longint'(cam_fx) * longint'(cam_base)) / (64 * longint'(disp));
        if (depth < cam_near || depth > cam_far)
            return 0;
        pt.x = lateral_coord(col, cam_cx, depth, cam_fx);
        pt.y = lateral_coord(row, cam_cy, depth, cam_fy);
        pt.z = (depth > 64'd67108863) ? {dtp_pkg::OUT_W{1'b1}} : dtp_pkg::OUT_W'(depth);
        return 1;
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [dtp_pkg::OUT_W-1:0] got,
                                   input logic [dtp_pkg::OUT_W-1:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Appends one point to the list of points still to arrive.
    task automatic queue_point(input point_t pt);
        pending_points = {pending_points, pt};
    endtask

    // Every emitted point is compared with the oldest pending one.
    always @(posedge clk)
    begin
        point_t want;
        if (rst_n && result_valid)
        begin
            if (pending_points.size() == 0)
            begin
                $display("unexpected point at %0t: %h %h %h", $realtime,
                         point_x, point_y, point_z);
                error_count++;
            end
            else
            begin
                want = pending_points.pop_front();
                if (point_x !== want.x)
                    report_mismatch("point_x", point_x, want.x);
                if (point_y !== want.y)
                    report_mismatch("point_y", point_y, want.y);
                if (point_z !== want.z)
                    report_mismatch("point_z", point_z, want.z);
            end
        end
    end

    // Register write; only called while the block holds no pixel in flight.
    // The write enable stays high for back-to-back writes and is dropped by
    // the caller after the last one.
    task automatic write_reg(input dtp_pkg::cfg_idx_t idx,
                             input logic [dtp_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        case (idx)
            dtp_pkg::CFG_FOCAL_X:  cam_fx   = value[dtp_pkg::FOCAL_W-1:0];
            dtp_pkg::CFG_FOCAL_Y:  cam_fy   = value[dtp_pkg::FOCAL_W-1:0];
            dtp_pkg::CFG_CENTER_X: cam_cx   = value[dtp_pkg::CENTER_W-1:0];
            dtp_pkg::CFG_CENTER_Y: cam_cy   = value[dtp_pkg::CENTER_W-1:0];
            dtp_pkg::CFG_BASELINE: cam_base = value[dtp_pkg::BASE_W-1:0];
            dtp_pkg::CFG_NEAR:     cam_near = value[dtp_pkg::LIMIT_W-1:0];
            dtp_pkg::CFG_FAR:      cam_far  = value[dtp_pkg::LIMIT_W-1:0];
            default:               ;
        endcase
    endtask

    task automatic write_camera(input logic [dtp_pkg::FOCAL_W-1:0]  fx,
                                input logic [dtp_pkg::FOCAL_W-1:0]  fy,
                                input logic [dtp_pkg::CENTER_W-1:0] cx,
                                input logic [dtp_pkg::CENTER_W-1:0] cy,
                                input logic [dtp_pkg::BASE_W-1:0]   b,
                                input logic [dtp_pkg::LIMIT_W-1:0]  nr,
                                input logic [dtp_pkg::LIMIT_W-1:0]  fr);
        write_reg(dtp_pkg::CFG_FOCAL_X, dtp_pkg::CFG_DATA_W'(fx));
        write_reg(dtp_pkg::CFG_FOCAL_Y, dtp_pkg::CFG_DATA_W'(fy));
        write_reg(dtp_pkg::CFG_CENTER_X, dtp_pkg::CFG_DATA_W'(cx));
        write_reg(dtp_pkg::CFG_CENTER_Y, dtp_pkg::CFG_DATA_W'(cy));
        write_reg(dtp_pkg::CFG_BASELINE, dtp_pkg::CFG_DATA_W'(b));
        write_reg(dtp_pkg::CFG_NEAR, nr);
        write_reg(dtp_pkg::CFG_FAR, fr);
        cfg_we <= 1'b0;
    endtask

    // Holds the sender off until every pending point has arrived, then lets the
    // pipeline empty of pixels that give no point.
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Presents one pixel, holding it until the transfer, and records what it
    // should produce. Bursts of back-to-back pixels alternate with random gaps.
    task automatic send_pixel(input pixel_row_t px);
        point_t pt;
        int     gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(30, 1);
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start           <= 1'b1;
        pixel_column    <= px.col;
        pixel_row       <= px.row;
        disparity       <= px.disp;
        disparity_valid <= px.valid;
        do
            @(posedge clk);
        while (busy);
        if (px.typed)
        begin
            if (px.has_point)
                queue_point(px.pt);
        end
        else if (predict_point(px.col, px.row, px.disp, px.valid, pt))
            queue_point(pt);
    endtask

    // Random pixel: mostly a disparity chosen to land inside the depth window,
    // otherwise anything at all, with some invalid flags.
    task automatic send_random_pixel();
        pixel_row_t      px;
        longint unsigned num;
        longint unsigned target;
        longint unsigned d;
        px.col       = dtp_pkg::COORD_BITS'($urandom);
        px.row       = dtp_pkg::COORD_BITS'($urandom);
        px.valid     = ($urandom_range(9, 0) != 0);
        px.typed     = 0;
        px.has_point = 0;
        px.pt        = '0;
        if ($urandom_range(4, 0) != 0)
        begin
            num    = longint'(cam_fx) * longint'(cam_base);
            target = $urandom_range(cam_far, cam_near);
            d      = (target == 0) ? 65535 : num / (64 * target);
            if ($urandom_range(1, 0) == 1)
                d = d + 1;
            px.disp = (d == 0) ? 16'd1 : (d > 65535) ? 16'hFFFF : d[15:0];
        end
        else
        begin
            px.disp = ($urandom_range(15, 0) == 0) ? '0
                      : dtp_pkg::DISPARITY_BITS'($urandom);
        end
        send_pixel(px);
    endtask

    task automatic random_phase(input int count);
        repeat (count) send_random_pixel();
        wait_drained();
    endtask

    // The directed table runs under the reset registers. Depth at reset is
    // 983000 / disparity, and the principal point is column 320, row 240.
    pixel_row_t directed[] = '{
        '{12'd320,  12'd240,  16'd96,    1'b1, 1, 1, '{26'd0, 26'd0, 26'd10239}},
        '{12'd320,  12'd240,  16'd4795,  1'b1, 1, 1, '{26'd0, 26'd0, 26'd205}},
        '{12'd320,  12'd240,  16'd4800,  1'b1, 1, 0, '0},
        '{12'd320,  12'd240,  16'd1,     1'b1, 1, 0, '0},
        '{12'd4095, 12'd4095, 16'hFFFF,  1'b1, 1, 0, '0},
        '{12'd320,  12'd240,  16'd0,     1'b1, 1, 0, '0},
        '{12'd320,  12'd240,  16'd96,    1'b0, 1, 0, '0},
        '{12'd0,    12'd0,    16'hFFFF,  1'b0, 1, 0, '0},
        '{12'd0,    12'd0,    16'd96,    1'b1, 0, 0, '0},
        '{12'd4095, 12'd4095, 16'd96,    1'b1, 0, 0, '0},
        '{12'd0,    12'd4095, 16'd200,   1'b1, 0, 0, '0},
        '{12'd4095, 12'd0,    16'd1000,  1'b1, 0, 0, '0},
        '{12'd321,  12'd239,  16'd4795,  1'b1, 0, 0, '0},
        '{12'd1234, 12'd3000, 16'd97,    1'b1, 0, 0, '0},
        '{12'd319,  12'd241,  16'd2500,  1'b1, 0, 0, '0},
        '{12'd2048, 12'd2048, 16'd512,   1'b1, 0, 0, '0}
    };

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        pixel_column    = '0;
        pixel_row       = '0;
        disparity       = '0;
        disparity_valid = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = dtp_pkg::CFG_FOCAL_X;
        cfg_wdata       = '0;
        error_count     = 0;
        burst_left      = 0;
        cam_fx   = dtp_pkg::RST_FOCAL_X;
        cam_fy   = dtp_pkg::RST_FOCAL_Y;
        cam_cx   = dtp_pkg::RST_CENTER_X;
        cam_cy   = dtp_pkg::RST_CENTER_Y;
        cam_base = dtp_pkg::RST_BASELINE;
        cam_near = dtp_pkg::RST_NEAR;
        cam_far  = dtp_pkg::RST_FAR;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_pixel(directed[i]);
        wait_drained();

        // Reset registers with random pixels.
        random_phase(140);

        // Widest registers: long x focal and baseline, full window, far corners.
        write_camera(20'hFFFFF, 20'd1, 16'd0, 16'hFFFF, 16'hFFFF, 26'd0, 26'h3FFFFFF);
        random_phase(120);

        // Zero focal lengths: depth is always zero and accepted with a zero window.
        write_camera(20'd0, 20'd0, 16'hFFFF, 16'd0, 16'd1, 26'd0, 26'd0);
        random_phase(60);

        // Short focal on x, long on y, so both saturations and tiny values occur.
        write_camera(20'd1, 20'hFFFFF, 16'd32768, 16'd32768, 16'hFFFF, 26'd0, 26'd100000);
        random_phase(100);

        // Random camera setups with a window that keeps most pixels.
        repeat (4)
        begin
            logic [dtp_pkg::LIMIT_W-1:0] nr;
            nr = dtp_pkg::LIMIT_W'($urandom_range(5000, 0));
            write_camera(dtp_pkg::FOCAL_W'($urandom), dtp_pkg::FOCAL_W'($urandom),
                         dtp_pkg::CENTER_W'($urandom), dtp_pkg::CENTER_W'($urandom),
                         dtp_pkg::BASE_W'($urandom), nr,
                         nr + dtp_pkg::LIMIT_W'($urandom_range(33554431, 0)));
            random_phase(120);
        end

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
